@@ hdl/kmc_pkg.sv @@
package kmc_pkg;

    // Port widths fixed by the word format
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int QUERY_W     = 16;
    localparam int INDEX_W     = 16;
    localparam int COUNT_OUT_W = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Sequence tracking widths
    localparam int K_W     = 4;
    localparam int RUN_W   = 4;
    localparam int PHASE_W = 8;

    localparam logic [RUN_W-1:0]   RUN_MAX      = 4'd15;
    localparam logic [K_W-1:0]     WL_RESET     = 4'd8;
    localparam logic [PHASE_W-1:0] STRIDE_RESET = 8'd1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE      = 1'd1;

    // Nucleotide characters
    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    // Base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // Word operations
    typedef enum logic [OP_W-1:0] {
        OP_CHAR  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_READ  = 2'd2
    } t_op;

endpackage

@@ hdl/kmc_table.sv @@
module kmc_table #(
    parameter int ADDR_W     = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr_a,
    input  logic [ADDR_W-1:0]     i_rd_addr_b,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [COUNT_BITS-1:0] i_wr_data,
    output logic [COUNT_BITS-1:0] o_rd_data_a,
    output logic [COUNT_BITS-1:0] o_rd_data_b,
    output logic                  o_busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];

    logic                  r_busy;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [COUNT_BITS-1:0] r_rd_a;
    logic [COUNT_BITS-1:0] r_rd_b;
    logic [ADDR_W-1:0]     r_rd_addr_a;
    logic [ADDR_W-1:0]     r_rd_addr_b;
    logic                  r_lw_valid;
    logic [ADDR_W-1:0]     r_lw_addr;
    logic [COUNT_BITS-1:0] r_lw_data;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // Select the write source: clearing pass or counter update
    always_comb begin
        if (r_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = i_wr_en;
            mem_waddr = i_wr_addr;
            mem_wdata = i_wr_data;
        end
    end

    // Table storage: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_rd_en) begin
            r_rd_a      <= r_mem[i_rd_addr_a];
            r_rd_b      <= r_mem[i_rd_addr_b];
            r_rd_addr_a <= i_rd_addr_a;
            r_rd_addr_b <= i_rd_addr_b;
        end
    end

    // Sweep every entry to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ADDR_W{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Hold the latest counter write for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (!r_busy && i_wr_en) begin
            r_lw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_wr_en) begin
            r_lw_addr <= i_wr_addr;
            r_lw_data <= i_wr_data;
        end
    end

    // Forward a write that landed on the same edge as the read
    assign o_rd_data_a = (r_lw_valid && (r_lw_addr == r_rd_addr_a)) ? r_lw_data : r_rd_a;
    assign o_rd_data_b = (r_lw_valid && (r_lw_addr == r_rd_addr_b)) ? r_lw_data : r_rd_b;
    assign o_busy      = r_busy;

endmodule

@@ hdl/kmer_count_histogram.sv @@
// An accepted word goes through the update stage, then the result registers,
// and is shown with o_done high for one cycle; the receiver cannot stall it.
// Throughput: one word per cycle unless busy, set by the table read-modify-write,
// which forwards the previous write so back-to-back hits on one entry count right.
// Reset (synchronous, active low) clears the sequence state and starts a pass
// that zeroes the table, one entry a cycle, with o_busy high.
module kmer_count_histogram #(
    parameter int MAX_WORD   = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kmc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [kmc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [kmc_pkg::OP_W-1:0]          i_op,
    input  logic [kmc_pkg::CHAR_W-1:0]        i_base_char,
    input  logic [kmc_pkg::QUERY_W-1:0]       i_query_index,
    output logic                              o_done,
    output logic                              o_counted,
    output logic                              o_bad_char,
    output logic [kmc_pkg::INDEX_W-1:0]       o_word_index,
    output logic [kmc_pkg::COUNT_OUT_W-1:0]   o_word_count,
    output logic [kmc_pkg::INDEX_W-1:0]       o_rc_index,
    output logic [kmc_pkg::COUNT_OUT_W-1:0]   o_rc_count
);
    import kmc_pkg::*;

    localparam int ADDR_W = 2 * MAX_WORD;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [COUNT_BITS-1:0] t_count;

    // Reverse complement of a word of k bases
    function automatic t_addr rev_comp(input t_addr idx, input logic [K_W-1:0] k);
        t_addr      full;
        logic [4:0] sh;
        for (int i = 0; i < MAX_WORD; i++) begin
            full[2*(MAX_WORD-1-i) +: 2] = ~idx[2*i +: 2];
        end
        sh = 5'((MAX_WORD - int'(k)) * 2);
        return full >> sh;
    endfunction

    // Configuration registers
    logic [K_W-1:0]     r_word_length;
    logic [PHASE_W-1:0] r_stride;

    // Sequence state
    t_addr              r_window;
    logic [RUN_W-1:0]   r_valid_run;
    logic [RUN_W-1:0]   r_seen;
    logic [PHASE_W-1:0] r_phase;
    t_addr              n_window;
    logic [RUN_W-1:0]   n_valid_run;
    logic [RUN_W-1:0]   n_seen;
    logic [PHASE_W-1:0] n_phase;

    // Update stage
    logic  r_b_valid;
    t_op   r_b_op;
    logic  r_b_tally;
    logic  r_b_bad;
    t_addr r_b_idx;
    t_addr r_b_rc;

    // Result registers
    logic                   r_done;
    logic                   r_counted;
    logic                   r_bad_char;
    t_addr                  r_word_index;
    t_count                 r_word_count;
    t_addr                  r_rc_index;
    t_count                 r_rc_count;

    logic               accept;
    t_op                op;
    logic [K_W-1:0]     k_eff;
    t_addr              mask;
    logic [PHASE_W-1:0] stride_eff;
    logic [1:0]         code;
    logic               bad;
    logic               full;
    logic               tally;
    t_addr              rd_addr;
    t_addr              rd_rc;
    t_count             data_a;
    t_count             data_b;
    t_count             inc_count;
    logic               wr_en;
    logic               busy;

    assign accept = i_start && !busy;
    assign op     = t_op'(i_op);

    // Clamp word length and stride into their working ranges
    always_comb begin
        if (r_word_length == '0) begin
            k_eff = K_W'(1);
        end else if (r_word_length > K_W'(MAX_WORD)) begin
            k_eff = K_W'(MAX_WORD);
        end else begin
            k_eff = r_word_length;
        end
        stride_eff = (r_stride == '0) ? PHASE_W'(1) : r_stride;
    end

    assign mask = ~({ADDR_W{1'b1}} << {k_eff, 1'b0});

    // Decode the character
    always_comb begin
        bad = 1'b0;
        case (i_base_char)
            CH_A_UP, CH_A_LO: code = CODE_A;
            CH_C_UP, CH_C_LO: code = CODE_C;
            CH_G_UP, CH_G_LO: code = CODE_G;
            CH_T_UP, CH_T_LO: code = CODE_T;
            default: begin
                code = CODE_A;
                bad  = 1'b1;
            end
        endcase
    end

    // Advance the window, runs and phase
    always_comb begin
        n_window    = r_window;
        n_valid_run = r_valid_run;
        n_seen      = r_seen;
        n_phase     = r_phase;
        full        = 1'b0;
        tally       = 1'b0;
        case (op)
            OP_CHAR: begin
                if (bad) begin
                    n_valid_run = '0;
                end else if (r_valid_run < RUN_MAX) begin
                    n_valid_run = r_valid_run + 1'b1;
                end
                n_window = t_addr'({r_window, code}) & mask;
                full     = ({1'b0, r_seen} + 5'd1) >= {1'b0, k_eff};
                if (r_seen < RUN_MAX) begin
                    n_seen = r_seen + 1'b1;
                end
                if (full) begin
                    tally = (r_phase == '0) && (n_valid_run >= k_eff);
                    if (({1'b0, r_phase} + 9'd1) >= {1'b0, stride_eff}) begin
                        n_phase = '0;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
            OP_BEGIN: begin
                n_window    = '0;
                n_valid_run = '0;
                n_seen      = '0;
                n_phase     = '0;
            end
            default: begin
            end
        endcase
    end

    // Table addresses for this word
    always_comb begin
        if (op == OP_CHAR) begin
            rd_addr = n_window;
        end else begin
            rd_addr = t_addr'(i_query_index) & mask;
        end
        rd_rc = rev_comp(rd_addr, k_eff);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= WL_RESET;
            r_stride      <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WORD_LENGTH: r_word_length <= i_cfg_data[K_W-1:0];
                CFG_STRIDE:      r_stride      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_valid_run <= '0;
            r_seen      <= '0;
            r_phase     <= '0;
        end else if (accept) begin
            r_window    <= n_window;
            r_valid_run <= n_valid_run;
            r_seen      <= n_seen;
            r_phase     <= n_phase;
        end
    end

    // Hand the word to the update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_op    <= op;
            r_b_tally <= tally;
            r_b_bad   <= bad && (op == OP_CHAR);
            r_b_idx   <= rd_addr;
            r_b_rc    <= rd_rc;
        end
    end

    kmc_table #(
        .ADDR_W     (ADDR_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_addr),
        .i_rd_addr_b (rd_rc),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_b_idx),
        .i_wr_data   (inc_count),
        .o_rd_data_a (data_a),
        .o_rd_data_b (data_b),
        .o_busy      (busy)
    );

    // Saturating increment and write back
    assign inc_count = (data_a == {COUNT_BITS{1'b1}}) ? data_a : data_a + 1'b1;
    assign wr_en     = r_b_valid && (r_b_op == OP_CHAR) && r_b_tally;

    // Build the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_counted    <= 1'b0;
        r_bad_char   <= 1'b0;
        r_word_index <= '0;
        r_word_count <= '0;
        r_rc_index   <= '0;
        r_rc_count   <= '0;
        case (r_b_op)
            OP_CHAR: begin
                r_bad_char <= r_b_bad;
                if (r_b_tally) begin
                    r_counted    <= 1'b1;
                    r_word_index <= r_b_idx;
                    r_word_count <= inc_count;
                    r_rc_index   <= r_b_rc;
                end
            end
            OP_READ: begin
                r_word_index <= r_b_idx;
                r_word_count <= data_a;
                r_rc_index   <= r_b_rc;
                r_rc_count   <= data_b;
            end
            default: begin
            end
        endcase
    end

    assign o_busy       = busy;
    assign o_done       = r_done;
    assign o_counted    = r_counted;
    assign o_bad_char   = r_bad_char;
    assign o_word_index = INDEX_W'(r_word_index);
    assign o_word_count = COUNT_OUT_W'(r_word_count);
    assign o_rc_index   = INDEX_W'(r_rc_index);
    assign o_rc_count   = COUNT_OUT_W'(r_rc_count);

endmodule

@@ hdl/kmc_checker.sv @@
module kmc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic                              o_done,
    input logic                              o_counted,
    input logic                              o_bad_char,
    input logic [kmc_pkg::COUNT_OUT_W-1:0]   o_rc_count
);
    import kmc_pkg::*;

    // Reset starts the table clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("table not clearing after reset");

    // Every accepted word gives one result on o_done
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_done)
        else $error("accepted word produced no result");

    // No result without an accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> ##1 !o_done)
        else $error("result without accepted word");

    // A tallied window never holds a rejected character
    a_tally_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_counted) |-> (!o_bad_char && (o_rc_count == '0)))
        else $error("tallied window flagged bad or carries rc count");

endmodule

bind kmer_count_histogram kmc_checker u_kmc_checker (.*);

@@ bench/tb_kmer_count_histogram.sv @@
module tb_kmer_count_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import kmc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int MAX_K        = 8;
    localparam int RUN_CAP      = 15;
    localparam int DRAIN_CYCLES = 4;
    localparam int N_PHASES     = 12;
    localparam int PHASE_WORDS  = 120;
    localparam int REPORT_LIMIT = 10;
    localparam int N_DIRECTED   = 22;

    // Op value 3 has no meaning in the block; it must come back all zero
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic [CHAR_W-1:0] CH_N_UP = 8'h4E;

    localparam logic [CHAR_W-1:0] BASE_CHARS [8] = '{
        CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP, CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO
    };

    typedef struct packed {
        logic                   counted;
        logic                   bad_char;
        logic [INDEX_W-1:0]     word_index;
        logic [COUNT_OUT_W-1:0] word_count;
        logic [INDEX_W-1:0]     rc_index;
        logic [COUNT_OUT_W-1:0] rc_count;
    } kmer_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  ch;
        logic [QUERY_W-1:0] query;
        logic               fixed;
        kmer_result_t       res;
    } stim_row_t;

    // Directed words; rows with fixed set carry their result typed in
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_READ,  8'h00,   16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd0, 16'hFFFF, 32'd0}},
        '{OP_READ,  8'hFF,   16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'hFFFF, 32'd0, 16'h0000, 32'd0}},
        '{OP_SPARE, 8'hFF,   16'hFFFF, 1'b1, '0},
        '{OP_BEGIN, 8'hFF,   16'hFFFF, 1'b1, '0},
        '{OP_CHAR,  8'h00,   16'hFFFF, 1'b1, '{1'b0, 1'b1, 16'h0000, 32'd0, 16'h0000, 32'd0}},
        '{OP_CHAR,  8'hFF,   16'h0000, 1'b1, '{1'b0, 1'b1, 16'h0000, 32'd0, 16'h0000, 32'd0}},
        '{OP_BEGIN, CH_A_UP, 16'h0000, 1'b1, '0},
        '{OP_CHAR,  CH_A_UP, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_C_UP, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_G_UP, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_T_UP, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_A_LO, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_C_LO, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_G_LO, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_T_LO, 16'h0000, 1'b1, '{1'b1, 1'b0, 16'h1B1B, 32'd1, 16'h1B1B, 32'd0}},
        '{OP_CHAR,  CH_T_UP, 16'h0000, 1'b0, '0},
        '{OP_CHAR,  CH_N_UP, 16'h0000, 1'b1, '{1'b0, 1'b1, 16'h0000, 32'd0, 16'h0000, 32'd0}},
        '{OP_CHAR,  CH_G_UP, 16'h0000, 1'b0, '0},
        '{OP_READ,  8'h00,   16'h1B1B, 1'b0, '0},
        '{OP_BEGIN, 8'h00,   16'h0000, 1'b1, '0},
        '{OP_CHAR,  CH_T_LO, 16'h0000, 1'b0, '0},
        '{OP_READ,  8'h00,   16'h0000, 1'b0, '0}
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_start       = 1'b0;
    logic [OP_W-1:0]        i_op          = '0;
    logic [CHAR_W-1:0]      i_base_char   = '0;
    logic [QUERY_W-1:0]     i_query_index = '0;
    logic                   o_busy;
    logic                   o_done;
    logic                   o_counted;
    logic                   o_bad_char;
    logic [INDEX_W-1:0]     o_word_index;
    logic [COUNT_OUT_W-1:0] o_word_count;
    logic [INDEX_W-1:0]     o_rc_index;
    logic [COUNT_OUT_W-1:0] o_rc_count;

    kmer_count_histogram dut (.*);

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Shadow of the block: sequence state, registers and the count table
    int                     kmer_window;
    int                     valid_run_len;
    int                     chars_seen;
    int                     stride_phase;
    logic [K_W-1:0]         wl_reg        = WL_RESET;
    logic [PHASE_W-1:0]     stride_reg    = STRIDE_RESET;
    bit [COUNT_OUT_W-1:0]   kmer_tally [0:(1 << (2 * MAX_K)) - 1];
    logic [INDEX_W-1:0]     last_tallied;

    kmer_result_t           pending_results [$];
    int                     mismatches;

    function automatic int eff_word_length();
        if (wl_reg == 0) return 1;
        if (wl_reg > MAX_K) return MAX_K;
        return int'(wl_reg);
    endfunction

    function automatic int word_mask();
        return (1 << (2 * eff_word_length())) - 1;
    endfunction

    function automatic bit char_code(input logic [CHAR_W-1:0] ch, output logic [1:0] code);
        code = CODE_A;
        case (ch)
            CH_A_UP, CH_A_LO: code = CODE_A;
            CH_C_UP, CH_C_LO: code = CODE_C;
            CH_G_UP, CH_G_LO: code = CODE_G;
            CH_T_UP, CH_T_LO: code = CODE_T;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Read the word backwards, complementing each base
    function automatic logic [INDEX_W-1:0] rev_comp_index(input logic [INDEX_W-1:0] idx,
                                                          input int k);
        logic [INDEX_W-1:0] rc;
        rc = '0;
        for (int n = 0; n < k; n++) begin
            rc = {rc[INDEX_W-3:0], 2'd3 - idx[2*n +: 2]};
        end
        return rc;
    endfunction

    // Advance the shadow state by one accepted word and return its result
    task automatic predict_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [QUERY_W-1:0] query, output kmer_result_t res);
        int          k;
        int          mask;
        int          st;
        int          idx;
        bit          ok;
        bit          full;
        logic [1:0]  code;
        logic [INDEX_W-1:0] rc;
        k    = eff_word_length();
        mask = word_mask();
        st   = (stride_reg == 0) ? 1 : int'(stride_reg);
        res  = '0;
        case (op)
            OP_CHAR: begin
                ok = char_code(ch, code);
                if (!ok) begin
                    res.bad_char  = 1'b1;
                    valid_run_len = 0;
                end else if (valid_run_len < RUN_CAP) begin
                    valid_run_len++;
                end
                kmer_window = ((kmer_window << 2) | int'(code)) & mask;
                full = (chars_seen + 1) >= k;
                if (chars_seen < RUN_CAP) chars_seen++;
                if (full) begin
                    if (stride_phase == 0 && valid_run_len >= k) begin
                        idx = kmer_window & mask;
                        if (kmer_tally[idx] != '1) kmer_tally[idx]++;
                        res.counted    = 1'b1;
                        res.word_index = INDEX_W'(idx);
                        res.word_count = kmer_tally[idx];
                        res.rc_index   = rev_comp_index(INDEX_W'(idx), k);
                        last_tallied   = INDEX_W'(idx);
                    end
                    stride_phase = (stride_phase + 1 >= st) ? 0 : stride_phase + 1;
                end
            end
            OP_BEGIN: begin
                kmer_window   = 0;
                valid_run_len = 0;
                chars_seen    = 0;
                stride_phase  = 0;
            end
            OP_READ: begin
                idx = int'(query) & mask;
                rc  = rev_comp_index(INDEX_W'(idx), k);
                res.word_index = INDEX_W'(idx);
                res.word_count = kmer_tally[idx];
                res.rc_index   = rc;
                res.rc_count   = kmer_tally[rc];
            end
            default: ;
        endcase
    endtask

    // Present one word, hold it until accepted, then queue what it should return
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [QUERY_W-1:0] query, input logic fixed,
                             input kmer_result_t fixed_res);
        kmer_result_t res;
        i_start       <= 1'b1;
        i_op          <= op;
        i_base_char   <= ch;
        i_query_index <= query;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_word(op, ch, query, res);
        pending_results.push_back(fixed ? fixed_res : res);
    endtask

    // Write both registers on back-to-back edges; only called while idle
    task automatic write_config(input logic [CFG_DATA_W-1:0] wl_data,
                                input logic [CFG_DATA_W-1:0] st_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WORD_LENGTH;
        i_cfg_data  <= wl_data;
        @(posedge i_clk);
        wl_reg       = wl_data[K_W-1:0];
        i_cfg_index <= CFG_STRIDE;
        i_cfg_data  <= st_data;
        @(posedge i_clk);
        stride_reg   = st_data;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed bases, with bad bytes, restarts, reads and spare ops mixed in
    task automatic pick_word(output logic [OP_W-1:0] op, output logic [CHAR_W-1:0] ch,
                             output logic [QUERY_W-1:0] query);
        int r;
        r     = $urandom_range(0, 99);
        ch    = CHAR_W'($urandom_range(0, 255));
        query = QUERY_W'($urandom_range(0, 65535));
        if (r < 78) begin
            op = OP_CHAR;
            if ($urandom_range(0, 13) != 0) ch = BASE_CHARS[$urandom_range(0, 7)];
        end else if (r < 83) begin
            op = OP_BEGIN;
        end else if (r < 97) begin
            op = OP_READ;
            // Hit a live entry, with junk above the word bits
            if ($urandom_range(0, 1) == 0)
                query = last_tallied | (QUERY_W'($urandom) & ~QUERY_W'(word_mask()));
        end else begin
            op = OP_SPARE;
        end
    endtask

    function automatic string fmt_result(input kmer_result_t r);
        return $sformatf("counted=%0d bad=%0d idx=%h cnt=%0d rc=%h rc_cnt=%0d",
                         r.counted, r.bad_char, r.word_index, r.word_count,
                         r.rc_index, r.rc_count);
    endfunction

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        kmer_result_t got;
        kmer_result_t want;
        if (i_rst_n && o_done) begin
            got = {o_counted, o_bad_char, o_word_index, o_word_count, o_rc_index, o_rc_count};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result word: %s", $realtime, fmt_result(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result mismatch", $realtime);
                        $display("    expected %s", fmt_result(want));
                        $display("    actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    initial begin
        logic [OP_W-1:0]       op;
        logic [CHAR_W-1:0]     ch;
        logic [QUERY_W-1:0]    query;
        logic [CFG_DATA_W-1:0] wl_data;
        logic [CFG_DATA_W-1:0] st_data;
        int                    burst_left;
        int                    r;
        bit                    gapless;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Hold off until the table clear finishes
        while (o_busy) @(posedge i_clk);

        foreach (directed_rows[n]) begin
            send_word(directed_rows[n].op, directed_rows[n].ch, directed_rows[n].query,
                      directed_rows[n].fixed, directed_rows[n].res);
        end
        i_start <= 1'b0;

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin wl_data = 8'h01; st_data = 8'h01; end
                1: begin wl_data = 8'h08; st_data = 8'hFF; end
                2: begin wl_data = 8'h00; st_data = 8'h00; end
                3: begin wl_data = 8'hFF; st_data = 8'h02; end
                4: begin wl_data = 8'h02; st_data = 8'h03; end
                default: begin
                    wl_data = CFG_DATA_W'($urandom_range(0, 255));
                    r = $urandom_range(0, 9);
                    if (r < 6)       st_data = CFG_DATA_W'($urandom_range(1, 4));
                    else if (r == 6) st_data = 8'h00;
                    else if (r == 7) st_data = 8'hFF;
                    else             st_data = CFG_DATA_W'($urandom_range(0, 255));
                end
            endcase
            write_config(wl_data, st_data);

            gapless    = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Drop start between bursts unless this phase runs flat out
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if (!gapless) begin
                        i_start <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    end
                end
                burst_left--;
                pick_word(op, ch, query);
                send_word(op, ch, query, 1'b0, '0);
            end
            i_start <= 1'b0;
        end

        for (int w = 0; w < 200 && pending_results.size() != 0; w++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += pending_results.size();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run ceiling: table clear plus every word at its longest gap, many times over
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ kmer_count_histogram.f @@
hdl/kmc_pkg.sv
hdl/kmc_table.sv
hdl/kmer_count_histogram.sv
hdl/kmc_checker.sv
bench/tb_kmer_count_histogram.sv
